### hdl/median_filter_3x3_red_key_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the 3x3 red-keyed median filter.
// The macros expect the clock aclk and the active-low reset aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef MEDIAN_FILTER_3X3_RED_KEY_ASSERT_SVH
`define MEDIAN_FILTER_3X3_RED_KEY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MF3_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MF3_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mf3_pkg.sv
// ----------------------------------------------------------------------------
// mf3_pkg
// Types, constants and the exchange-sort pass shared by the median filter.
// ----------------------------------------------------------------------------
package mf3_pkg;

    localparam int MAX_WIDTH_DEFAULT = 1024;
    localparam int MAX_HEIGHT        = 4096;
    localparam int MIN_SIZE          = 3;
    localparam int FRAME_SIZE_RESET  = 1024;

    localparam int WINDOW_SIZE = 9;
    localparam int MEDIAN_POS  = WINDOW_SIZE / 2;
    // Passes after the one that fixes the median position never touch it.
    localparam int NUM_PASSES  = MEDIAN_POS + 1;

    localparam int FRAME_WIDTH_W  = 11;
    localparam int FRAME_HEIGHT_W = 13;
    localparam int ROW_W          = 12;
    localparam int OUT_X_W        = 10;
    localparam int OUT_Y_W        = 12;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 13;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    typedef pixel_t [WINDOW_SIZE-1:0] win_t;

    typedef struct packed {
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } in_beat_t;

    typedef struct packed {
        logic [OUT_X_W-1:0] out_x;
        logic [OUT_Y_W-1:0] out_y;
        logic [7:0]         out_red;
        logic [7:0]         out_green;
        logic [7:0]         out_blue;
        logic               frame_done;
    } out_beat_t;

    typedef struct packed {
        logic [OUT_X_W-1:0] out_x;
        logic [OUT_Y_W-1:0] out_y;
        logic               frame_done;
    } meta_t;

    // One outer pass of the exchange sort: position i is compared with every
    // later position in order and swapped when its red is strictly greater.
    function automatic win_t exchange_pass(input win_t w, input int unsigned i);
        win_t   r;
        pixel_t t;
        r = w;
        for (int unsigned j = 1; j < WINDOW_SIZE; j++) begin
            if (j > i && r[i].red > r[j].red) begin
                t    = r[i];
                r[i] = r[j];
                r[j] = t;
            end
        end
        return r;
    endfunction

endpackage

### hdl/mf3_ram.sv
// ----------------------------------------------------------------------------
// mf3_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mf3_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/mf3_window.sv
// ----------------------------------------------------------------------------
// mf3_window
// Raster counters, two line buffers and the 3x3 window of unfiltered pixels.
// ----------------------------------------------------------------------------
module mf3_window #(
    parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEFAULT,
    localparam int XW       = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int WW       = $clog2(MAX_WIDTH + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                s_valid,
    input  mf3_pkg::in_beat_t                   s_data,
    input  logic [WW-1:0]                       width_eff,
    input  logic [mf3_pkg::FRAME_HEIGHT_W-1:0]  height_eff,
    output logic                                win_valid,
    output mf3_pkg::win_t                       win,
    output mf3_pkg::meta_t                      meta
);

    localparam int YW = mf3_pkg::ROW_W;

    logic                accept;
    logic [XW-1:0]       col_reg, col_next;
    logic [YW-1:0]       row_reg, row_next;
    logic                wrap_col;
    logic [XW-1:0]       x_cur;
    logic [YW:0]         y_step;
    logic [YW-1:0]       y_cur;
    logic [WW-1:0]       x_inc;
    logic [YW:0]         y_inc;
    logic                last_col;
    logic                emit_cur;
    mf3_pkg::meta_t      meta_cur;
    mf3_pkg::pixel_t     pix_cur;

    logic                v1_reg;
    logic                emit1_reg;
    mf3_pkg::meta_t      meta1_reg;
    mf3_pkg::pixel_t     pix1_reg;
    logic [XW-1:0]       addr1_reg;

    logic [$bits(mf3_pkg::pixel_t)-1:0] upper_q, middle_q;
    mf3_pkg::pixel_t     top, mid;
    logic                advance;
    mf3_pkg::pixel_t     wcol_reg [6];

    assign accept  = s_valid && en;
    assign advance = v1_reg && en;

    // Position of the arriving pixel, including the wrap that follows a size
    // change between frames or mid-frame.
    always_comb begin
        wrap_col = WW'(col_reg) >= width_eff;
        x_cur    = wrap_col ? '0 : col_reg;
        y_step   = wrap_col ? ({1'b0, row_reg} + (YW+1)'(1)) : {1'b0, row_reg};
        y_cur    = (y_step >= height_eff) ? '0 : y_step[YW-1:0];
        x_inc    = WW'(x_cur) + WW'(1);
        y_inc    = {1'b0, y_cur} + (YW+1)'(1);
        last_col = x_inc >= width_eff;
        col_next = last_col ? '0 : x_inc[XW-1:0];
        if (last_col) begin
            row_next = (y_inc >= height_eff) ? '0 : y_inc[YW-1:0];
        end else begin
            row_next = y_cur;
        end
        emit_cur            = (x_cur >= XW'(2)) && (y_cur >= YW'(2));
        meta_cur.out_x      = mf3_pkg::OUT_X_W'(WW'(x_cur) - WW'(1));
        meta_cur.out_y      = mf3_pkg::OUT_Y_W'(y_cur - YW'(1));
        meta_cur.frame_done = (x_inc == width_eff) && (y_inc == height_eff);
        pix_cur.red         = s_data.in_red;
        pix_cur.green       = s_data.in_green;
        pix_cur.blue        = s_data.in_blue;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            v1_reg  <= 1'b0;
        end else if (en) begin
            v1_reg <= accept;
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            emit1_reg <= emit_cur;
            meta1_reg <= meta_cur;
            pix1_reg  <= pix_cur;
            addr1_reg <= x_cur;
        end
    end

    // Both buffers are read when a pixel arrives and written back at the registered
    // address once that pixel advances, as the row above moves up and the new pixel takes its place.
    mf3_ram #(
        .WIDTH ($bits(mf3_pkg::pixel_t)),
        .DEPTH (MAX_WIDTH)
    ) u_line_upper (
        .aclk  (aclk),
        .we    (advance),
        .waddr (addr1_reg),
        .wdata (middle_q),
        .re    (accept),
        .raddr (x_cur),
        .rdata (upper_q)
    );

    mf3_ram #(
        .WIDTH ($bits(mf3_pkg::pixel_t)),
        .DEPTH (MAX_WIDTH)
    ) u_line_middle (
        .aclk  (aclk),
        .we    (advance),
        .waddr (addr1_reg),
        .wdata (pix1_reg),
        .re    (accept),
        .raddr (x_cur),
        .rdata (middle_q)
    );

    assign top = mf3_pkg::pixel_t'(upper_q);
    assign mid = mf3_pkg::pixel_t'(middle_q);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 6; k++) begin
                wcol_reg[k] <= '0;
            end
        end else if (advance) begin
            wcol_reg[0] <= wcol_reg[3];
            wcol_reg[1] <= wcol_reg[4];
            wcol_reg[2] <= wcol_reg[5];
            wcol_reg[3] <= top;
            wcol_reg[4] <= mid;
            wcol_reg[5] <= pix1_reg;
        end
    end

    always_comb begin
        win[0] = wcol_reg[0];
        win[1] = wcol_reg[3];
        win[2] = top;
        win[3] = wcol_reg[1];
        win[4] = wcol_reg[4];
        win[5] = mid;
        win[6] = wcol_reg[2];
        win[7] = wcol_reg[5];
        win[8] = pix1_reg;
    end

    assign win_valid = v1_reg && emit1_reg;
    assign meta      = meta1_reg;

`include "median_filter_3x3_red_key_assert.svh"

    `MF3_ASSERT_IMPL(a_no_rw_collision, advance && accept, addr1_reg != x_cur, "line buffer read and write hit the same column")
    `MF3_ASSERT_NEXT(a_stage_hold, v1_reg && !en, v1_reg && $stable(meta1_reg), "stalled window stage lost its pixel")

endmodule

### hdl/mf3_sort.sv
// ----------------------------------------------------------------------------
// mf3_sort
// Exchange-sort passes on the red key, one pass per pipeline stage.
// ----------------------------------------------------------------------------
module mf3_sort (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  mf3_pkg::win_t      in_win,
    input  mf3_pkg::meta_t     in_meta,
    output logic               out_valid,
    output mf3_pkg::out_beat_t out_data
);

    localparam int NP = mf3_pkg::NUM_PASSES;

    mf3_pkg::win_t      stage_win   [NP];
    mf3_pkg::meta_t     stage_meta  [NP];
    logic               stage_valid [NP];

    mf3_pkg::win_t      win_reg     [1:NP-1];
    mf3_pkg::meta_t     meta_reg    [1:NP-1];
    logic               valid_reg   [1:NP-1];

    mf3_pkg::win_t      last_win;
    logic               out_valid_reg;
    mf3_pkg::out_beat_t out_reg;

    always_comb begin
        stage_win[0]   = in_win;
        stage_meta[0]  = in_meta;
        stage_valid[0] = in_valid;
        for (int k = 1; k < NP; k++) begin
            stage_win[k]   = win_reg[k];
            stage_meta[k]  = meta_reg[k];
            stage_valid[k] = valid_reg[k];
        end
    end

    for (genvar k = 0; k < NP - 1; k++) begin : g_pass
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k+1] <= 1'b0;
            end else if (en) begin
                valid_reg[k+1] <= stage_valid[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                win_reg[k+1]  <= mf3_pkg::exchange_pass(stage_win[k], k);
                meta_reg[k+1] <= stage_meta[k];
            end
        end
    end

    // The final pass settles the median position; only that entry is kept.
    assign last_win = mf3_pkg::exchange_pass(stage_win[NP-1], NP - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= stage_valid[NP-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_reg.out_x      <= stage_meta[NP-1].out_x;
            out_reg.out_y      <= stage_meta[NP-1].out_y;
            out_reg.out_red    <= last_win[mf3_pkg::MEDIAN_POS].red;
            out_reg.out_green  <= last_win[mf3_pkg::MEDIAN_POS].green;
            out_reg.out_blue   <= last_win[mf3_pkg::MEDIAN_POS].blue;
            out_reg.frame_done <= stage_meta[NP-1].frame_done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

### hdl/median_filter_3x3_red_key.sv
// ----------------------------------------------------------------------------
// median_filter_3x3_red_key: 3x3 median filter on RGB pixels, keyed on red.
// A result passes the window register and the five sort stages after its last window pixel is taken.
// Throughput: one pixel per cycle, set by the five-stage sort pipeline, unless the sink holds off a result.
// Reset (synchronous, aresetn low) clears counters, window and valid bits.
// ----------------------------------------------------------------------------
module median_filter_3x3_red_key #(
    parameter int MAX_WIDTH = mf3_pkg::MAX_WIDTH_DEFAULT,
    localparam int WW       = $clog2(MAX_WIDTH + 1)
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  mf3_pkg::in_beat_t                 s_data,

    output logic                              m_valid,
    input  logic                              m_ready,
    output mf3_pkg::out_beat_t                m_data,

    input  logic                              cfg_we,
    input  logic [mf3_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [mf3_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int HW = mf3_pkg::FRAME_HEIGHT_W;
    localparam int WIDTH_RESET = (mf3_pkg::FRAME_SIZE_RESET > MAX_WIDTH) ?
                                 MAX_WIDTH : mf3_pkg::FRAME_SIZE_RESET;

    // The frame size is clamped as it is written, so the datapath only ever
    // sees a width of 3 up to the line buffer depth and a height of 3 to 4096.
    logic [WW-1:0]                      width_eff_reg, width_eff_next;
    logic [HW-1:0]                      height_eff_reg, height_eff_next;
    logic [mf3_pkg::FRAME_WIDTH_W-1:0]  cfg_width;
    logic [HW-1:0]                      cfg_height;

    // The whole pipeline moves together. It stalls only when a finished
    // result sits in the output register and the sink does not take it.
    logic                               en;

    logic                               win_valid;
    mf3_pkg::win_t                      win;
    mf3_pkg::meta_t                     meta;

    assign cfg_width  = cfg_data[mf3_pkg::FRAME_WIDTH_W-1:0];
    assign cfg_height = cfg_data[HW-1:0];

    always_comb begin
        width_eff_next  = width_eff_reg;
        height_eff_next = height_eff_reg;
        if (cfg_we) begin
            case (cfg_index)
                mf3_pkg::REG_FRAME_WIDTH: begin
                    if (32'(cfg_width) < mf3_pkg::MIN_SIZE) begin
                        width_eff_next = WW'(mf3_pkg::MIN_SIZE);
                    end else if (32'(cfg_width) > MAX_WIDTH) begin
                        width_eff_next = WW'(MAX_WIDTH);
                    end else begin
                        width_eff_next = WW'(cfg_width);
                    end
                end
                mf3_pkg::REG_FRAME_HEIGHT: begin
                    if (32'(cfg_height) < mf3_pkg::MIN_SIZE) begin
                        height_eff_next = HW'(mf3_pkg::MIN_SIZE);
                    end else if (32'(cfg_height) > mf3_pkg::MAX_HEIGHT) begin
                        height_eff_next = HW'(mf3_pkg::MAX_HEIGHT);
                    end else begin
                        height_eff_next = cfg_height;
                    end
                end
                default: begin
                    // Writes to unused indexes are ignored.
                    width_eff_next  = width_eff_reg;
                    height_eff_next = height_eff_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_eff_reg  <= WW'(WIDTH_RESET);
            height_eff_reg <= HW'(mf3_pkg::FRAME_SIZE_RESET);
        end else begin
            width_eff_reg  <= width_eff_next;
            height_eff_reg <= height_eff_next;
        end
    end

    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // Front end: raster position, line buffers and the window registers.
    // Border pixels pass through here to fill the buffers but leave no beat.
    mf3_window #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_window (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .s_valid    (s_valid),
        .s_data     (s_data),
        .width_eff  (width_eff_reg),
        .height_eff (height_eff_reg),
        .win_valid  (win_valid),
        .win        (win),
        .meta       (meta)
    );

    // Back end: the exchange sort, one outer pass per stage, ending in the
    // output register that holds a beat until the sink accepts it.
    mf3_sort u_sort (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (win_valid),
        .in_win    (win),
        .in_meta   (meta),
        .out_valid (m_valid),
        .out_data  (m_data)
    );

`include "median_filter_3x3_red_key_assert.svh"

    `MF3_ASSERT_IMPL(a_out_row_interior, m_valid, m_data.out_y != '0, "result beat carries a border row")

endmodule
